[rtl/dcpq_pkg.sv]
// shared types and constants for the two-class priority request queue
package dcpq_pkg;

   // default ring depth
   localparam int QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int CONN_W = 16;
   localparam int SEQ_W = 32;
   localparam int LEN_W = 13;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam int MODE_W = 2;
   localparam int CAP_W = 5;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // word kind
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP = 1'b1;

   // stored descriptor
   typedef struct packed {
      logic [CONN_W-1:0] conn_id;
      logic [SEQ_W-1:0] seq_num;
      logic is_picture;
      logic [LEN_W-1:0] length;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   // scheduling modes
   typedef enum logic [MODE_W-1:0] {
      MODE_ANY = 2'd0,
      MODE_FIFO = 2'd1,
      MODE_HPIC = 2'd2,
      MODE_HPHC = 2'd3
   } sched_mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_PUSHED = 2'd0,
      ST_POPPED = 2'd1,
      ST_FULL = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_index_type;

   // controller states
   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_RESP = 1'b1
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic push_main;
      logic push_pic;
      logic pop_main;
      logic pop_pic;
      status_type status;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic main_empty;
      logic pic_empty;
      logic prio;
      logic favor_pic;
   } dp_stat_type;

endpackage

[rtl/dcpq_ram.sv]
// generic single-write, single-read ram with registered read data
module dcpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dcpq_ctrl.sv]
// controller: decides the action of each word and marks the response cycle
module dcpq_ctrl (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic req_kind,
   input logic req_is_picture,
   input dcpq_pkg::dp_stat_type stat,
   output dcpq_pkg::dp_cmd_type cmd,
   output logic rsp_valid
);
   import dcpq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic accept;
   logic take_main;
   logic pop_ok;

   // a new word is taken in every cycle, the response follows in the next cycle
   assign busy = 1'b0;
   assign accept = start && !busy;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      cmd = '0;
      cmd.status = ST_PUSHED;
      take_main = 1'b1;
      pop_ok = 1'b1;
      rsp_valid = 1'b0;
      state_in = state_ff;

      // pop source selection
      if (!stat.prio) begin
         take_main = 1'b1;
         pop_ok = !stat.main_empty;
      end else if (stat.favor_pic) begin
         take_main = stat.pic_empty;
         pop_ok = !(stat.main_empty && stat.pic_empty);
      end else begin
         take_main = !stat.main_empty;
         pop_ok = !(stat.main_empty && stat.pic_empty);
      end

      case (state_ff)
         CS_IDLE: begin
            rsp_valid = 1'b0;
         end
         CS_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase

      if (accept) begin
         cmd.load = 1'b1;
         state_in = CS_RESP;
         if (req_kind == KIND_PUSH) begin
            if (stat.full) begin
               cmd.status = ST_FULL;
            end else if (!stat.prio || !req_is_picture) begin
               cmd.push_main = 1'b1;
               cmd.status = ST_PUSHED;
            end else begin
               cmd.push_pic = 1'b1;
               cmd.status = ST_PUSHED;
            end
         end else begin
            if (!pop_ok) begin
               cmd.status = ST_EMPTY;
            end else if (take_main) begin
               cmd.pop_main = 1'b1;
               cmd.status = ST_POPPED;
            end else begin
               cmd.pop_pic = 1'b1;
               cmd.status = ST_POPPED;
            end
         end
      end else begin
         state_in = CS_IDLE;
      end
   end

endmodule

[rtl/dcpq_datapath.sv]
// datapath: config registers, ring pointers, counters, stores and response registers
module dcpq_datapath #(
   parameter int QUEUE_DEPTH = dcpq_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input dcpq_pkg::dp_cmd_type cmd,
   output dcpq_pkg::dp_stat_type stat,
   input logic [dcpq_pkg::CONN_W-1:0] req_conn_id,
   input logic [dcpq_pkg::SEQ_W-1:0] req_seq_num,
   input logic req_is_picture,
   input logic [dcpq_pkg::LEN_W-1:0] req_request_length,
   input logic csr_write,
   input logic [dcpq_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [dcpq_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [dcpq_pkg::STATUS_W-1:0] rsp_status,
   output logic [dcpq_pkg::CONN_W-1:0] rsp_out_conn_id,
   output logic [dcpq_pkg::SEQ_W-1:0] rsp_out_seq_num,
   output logic rsp_out_is_picture,
   output logic [dcpq_pkg::LEN_W-1:0] rsp_out_length,
   output logic [dcpq_pkg::COUNT_OUT_W-1:0] rsp_page_count,
   output logic [dcpq_pkg::COUNT_OUT_W-1:0] rsp_picture_count
);
   import dcpq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sched_mode_type mode_ff;
   logic [CAP_W-1:0] capacity_ff;
   logic [PTR_W-1:0] main_head_ff, main_tail_ff, pic_head_ff, pic_tail_ff;
   logic [CNT_W-1:0] main_count_ff, pic_count_ff;
   status_type rsp_status_ff;
   logic rsp_sel_main_ff;
   logic [CNT_W-1:0] eff_cap;
   logic [CNT_W:0] occupancy;
   desc_type wr_desc;
   desc_type main_rd, pic_rd, rsp_desc;

   // ring pointer step with wrap at the effective capacity
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
      logic [PTR_W:0] n;
      n = {1'b0, p} + (PTR_W+1)'(1);
      if (32'(n) >= 32'(cap)) begin
         return '0;
      end
      return n[PTR_W-1:0];
   endfunction

   // effective capacity, clamped to one and to the ring depth
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(capacity_ff) > 32'(QUEUE_DEPTH)) begin
         eff_cap = CNT_W'(QUEUE_DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   // status toward the controller
   assign occupancy = {1'b0, main_count_ff} + {1'b0, pic_count_ff};
   assign stat.full = occupancy >= {1'b0, eff_cap};
   assign stat.main_empty = main_count_ff == '0;
   assign stat.pic_empty = pic_count_ff == '0;
   assign stat.prio = (mode_ff == MODE_HPIC) || (mode_ff == MODE_HPHC);
   assign stat.favor_pic = mode_ff == MODE_HPIC;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ANY;
         capacity_ff <= CAP_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MODE: mode_ff <= sched_mode_type'(csr_data[MODE_W-1:0]);
            CSR_CAPACITY: capacity_ff <= csr_data[CAP_W-1:0];
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   // ring pointers and occupancy counters
   always_ff @(posedge clock) begin
      if (reset) begin
         main_head_ff <= '0;
         main_tail_ff <= '0;
         pic_head_ff <= '0;
         pic_tail_ff <= '0;
         main_count_ff <= '0;
         pic_count_ff <= '0;
      end else begin
         if (cmd.push_main) begin
            main_tail_ff <= advance(main_tail_ff, eff_cap);
            main_count_ff <= main_count_ff + CNT_W'(1);
         end
         if (cmd.pop_main) begin
            main_head_ff <= advance(main_head_ff, eff_cap);
            main_count_ff <= main_count_ff - CNT_W'(1);
         end
         if (cmd.push_pic) begin
            pic_tail_ff <= advance(pic_tail_ff, eff_cap);
            pic_count_ff <= pic_count_ff + CNT_W'(1);
         end
         if (cmd.pop_pic) begin
            pic_head_ff <= advance(pic_head_ff, eff_cap);
            pic_count_ff <= pic_count_ff - CNT_W'(1);
         end
      end
   end

   // descriptor to store
   always_comb begin
      wr_desc.conn_id = req_conn_id;
      wr_desc.seq_num = req_seq_num;
      wr_desc.is_picture = req_is_picture;
      wr_desc.length = req_request_length;
   end

   // main queue store
   dcpq_ram #(
      .WIDTH(DESC_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_main_ram (
      .clock(clock),
      .wr_en(cmd.push_main),
      .wr_addr(main_tail_ff),
      .wr_data(wr_desc),
      .rd_en(cmd.pop_main),
      .rd_addr(main_head_ff),
      .rd_data(main_rd)
   );

   // picture queue store
   dcpq_ram #(
      .WIDTH(DESC_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_pic_ram (
      .clock(clock),
      .wr_en(cmd.push_pic),
      .wr_addr(pic_tail_ff),
      .wr_data(wr_desc),
      .rd_en(cmd.pop_pic),
      .rd_addr(pic_head_ff),
      .rd_data(pic_rd)
   );

   // response status and source select
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= cmd.status;
         rsp_sel_main_ff <= cmd.pop_main;
      end
   end

   // popped descriptor, zero for any other status
   always_comb begin
      if (rsp_status_ff == ST_POPPED) begin
         rsp_desc = rsp_sel_main_ff ? main_rd : pic_rd;
      end else begin
         rsp_desc = '0;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_out_conn_id = rsp_desc.conn_id;
   assign rsp_out_seq_num = rsp_desc.seq_num;
   assign rsp_out_is_picture = rsp_desc.is_picture;
   assign rsp_out_length = rsp_desc.length;
   assign rsp_page_count = COUNT_OUT_W'(main_count_ff);
   assign rsp_picture_count = COUNT_OUT_W'(pic_count_ff);

endmodule

[rtl/dual_class_priority_request_queue_top.sv]
// two-class priority request queue: top level
// a word that is taken has its response on the rsp ports in the next cycle
// one word is taken per cycle and busy stays low; the store read is registered
// responses are never held off: each stands for exactly one cycle with rsp_valid
// reset (synchronous, active high) empties both queues, sets mode any and capacity 16
// store contents are not cleared by reset; no clearing pass is needed
module dual_class_priority_request_queue_top #(
   parameter int QUEUE_DEPTH = dcpq_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic req_kind,
   input logic [dcpq_pkg::CONN_W-1:0] req_conn_id,
   input logic [dcpq_pkg::SEQ_W-1:0] req_seq_num,
   input logic req_is_picture,
   input logic [dcpq_pkg::LEN_W-1:0] req_request_length,
   output logic rsp_valid,
   output logic [dcpq_pkg::STATUS_W-1:0] rsp_status,
   output logic [dcpq_pkg::CONN_W-1:0] rsp_out_conn_id,
   output logic [dcpq_pkg::SEQ_W-1:0] rsp_out_seq_num,
   output logic rsp_out_is_picture,
   output logic [dcpq_pkg::LEN_W-1:0] rsp_out_length,
   output logic [dcpq_pkg::COUNT_OUT_W-1:0] rsp_page_count,
   output logic [dcpq_pkg::COUNT_OUT_W-1:0] rsp_picture_count,
   input logic csr_valid,
   output logic csr_ready,
   input logic [dcpq_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [dcpq_pkg::CSR_DATA_W-1:0] csr_data
);
   import dcpq_pkg::*;

   dp_cmd_type cmd;
   dp_stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // controller
   dcpq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_is_picture(req_is_picture),
      .stat(stat),
      .cmd(cmd),
      .rsp_valid(rsp_valid)
   );

   // datapath
   dcpq_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_conn_id(req_conn_id),
      .req_seq_num(req_seq_num),
      .req_is_picture(req_is_picture),
      .req_request_length(req_request_length),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_status(rsp_status),
      .rsp_out_conn_id(rsp_out_conn_id),
      .rsp_out_seq_num(rsp_out_seq_num),
      .rsp_out_is_picture(rsp_out_is_picture),
      .rsp_out_length(rsp_out_length),
      .rsp_page_count(rsp_page_count),
      .rsp_picture_count(rsp_picture_count)
   );

endmodule

[dv/tb_dual_class_priority_request_queue_top.sv]
// self-checking testbench for the two-class priority request queue
`timescale 1ns / 100ps

module tb_dual_class_priority_request_queue_top;
   import dcpq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int RANDOM_WORDS = 1524;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam logic [LEN_W-1:0] LEN_MAX = 13'd8096;

   // one request word as the sender holds it
   typedef struct {
      logic kind;
      logic [CONN_W-1:0] conn_id;
      logic [SEQ_W-1:0] seq_num;
      logic is_picture;
      logic [LEN_W-1:0] length;
      bit wait_idle;
   } request_word_type;

   // one reply word of the queue
   typedef struct {
      status_type status;
      desc_type desc;
      logic [COUNT_OUT_W-1:0] page_count;
      logic [COUNT_OUT_W-1:0] picture_count;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = KIND_PUSH;
   logic [CONN_W-1:0] req_conn_id = '0;
   logic [SEQ_W-1:0] req_seq_num = '0;
   logic req_is_picture = 1'b0;
   logic [LEN_W-1:0] req_request_length = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [CONN_W-1:0] rsp_out_conn_id;
   logic [SEQ_W-1:0] rsp_out_seq_num;
   logic rsp_out_is_picture;
   logic [LEN_W-1:0] rsp_out_length;
   logic [COUNT_OUT_W-1:0] rsp_page_count;
   logic [COUNT_OUT_W-1:0] rsp_picture_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   dual_class_priority_request_queue_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_conn_id(req_conn_id),
      .req_seq_num(req_seq_num),
      .req_is_picture(req_is_picture),
      .req_request_length(req_request_length),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_conn_id(rsp_out_conn_id),
      .rsp_out_seq_num(rsp_out_seq_num),
      .rsp_out_is_picture(rsp_out_is_picture),
      .rsp_out_length(rsp_out_length),
      .rsp_page_count(rsp_page_count),
      .rsp_picture_count(rsp_picture_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the two rings, their pointers and the registers
   desc_type page_ring [DEPTH];
   desc_type pic_ring [DEPTH];
   logic [DEPTH-1:0] page_written = '0;
   logic [DEPTH-1:0] pic_written = '0;
   int page_head = 0;
   int page_tail = 0;
   int pic_head = 0;
   int pic_tail = 0;
   int page_fill = 0;
   int pic_fill = 0;
   sched_mode_type mode_now = MODE_ANY;
   logic [CAP_W-1:0] cap_now = CAP_RESET;

   request_word_type pending_requests[$];
   queue_reply_type awaited_replies[$];
   request_word_type req_now;
   int requests_taken = 0;
   int replies_seen = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 1;

   // capacity as the rings use it: zero acts as one, large values clip to depth
   function automatic int usable_slots();
      if (cap_now == 0) return 1;
      if (cap_now > DEPTH) return DEPTH;
      return int'(cap_now);
   endfunction

   function automatic int next_slot(int ptr, int lim);
      return (ptr + 1 >= lim) ? 0 : ptr + 1;
   endfunction

   // apply one word to the shadow rings and return the reply it causes
   function automatic queue_reply_type queue_reply(request_word_type w);
      queue_reply_type r;
      desc_type d;
      int lim;
      bit from_main;
      bit any_left;
      lim = usable_slots();
      r.status = ST_EMPTY;
      r.desc = '0;
      d.conn_id = w.conn_id;
      d.seq_num = w.seq_num;
      d.is_picture = w.is_picture;
      d.length = w.length;
      if (w.kind == KIND_PUSH) begin
         if (page_fill + pic_fill >= lim) begin
            r.status = ST_FULL;
         end else if (mode_now == MODE_ANY || mode_now == MODE_FIFO || !w.is_picture) begin
            page_ring[page_tail] = d;
            page_written[page_tail] = 1'b1;
            page_tail = next_slot(page_tail, lim);
            page_fill++;
            r.status = ST_PUSHED;
         end else begin
            pic_ring[pic_tail] = d;
            pic_written[pic_tail] = 1'b1;
            pic_tail = next_slot(pic_tail, lim);
            pic_fill++;
            r.status = ST_PUSHED;
         end
      end else begin
         // plain modes serve pages only, priority modes fall back to the other class
         if (mode_now == MODE_ANY || mode_now == MODE_FIFO) begin
            from_main = 1'b1;
            any_left = page_fill > 0;
         end else if (mode_now == MODE_HPIC) begin
            from_main = pic_fill == 0;
            any_left = page_fill + pic_fill > 0;
         end else begin
            from_main = page_fill > 0;
            any_left = page_fill + pic_fill > 0;
         end
         if (!any_left) begin
            r.status = ST_EMPTY;
         end else if (from_main) begin
            r.desc = page_ring[page_head];
            page_head = next_slot(page_head, lim);
            page_fill--;
            r.status = ST_POPPED;
         end else begin
            r.desc = pic_ring[pic_head];
            pic_head = next_slot(pic_head, lim);
            pic_fill--;
            r.status = ST_POPPED;
         end
      end
      r.page_count = COUNT_OUT_W'(page_fill);
      r.picture_count = COUNT_OUT_W'(pic_fill);
      return r;
   endfunction

   // register write, issued only while the queue is idle
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_MODE) mode_now = sched_mode_type'(val[MODE_W-1:0]);
      else cap_now = val;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_request(logic kind, logic [CONN_W-1:0] conn, logic [SEQ_W-1:0] seq,
                              logic pic, logic [LEN_W-1:0] len, bit hold);
      request_word_type w;
      w.kind = kind;
      w.conn_id = conn;
      w.seq_num = seq;
      w.is_picture = pic;
      w.length = len;
      w.wait_idle = hold;
      pending_requests.push_back(w);
   endtask

   // wait until every word went out and every reply came back
   task automatic drain_queue();
      do @(negedge clock);
      while (pending_requests.size() != 0 || start || awaited_replies.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // sender: bursts of words with random gaps, some words wait for an idle queue
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && busy === 1'b0) begin
            awaited_replies.push_back(queue_reply(req_now));
            requests_taken++;
         end
         if (!start || busy === 1'b0) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].wait_idle || requests_taken == replies_seen)) begin
               req_now = pending_requests.pop_front();
               start <= 1'b1;
               req_kind <= req_now.kind;
               req_conn_id <= req_now.conn_id;
               req_seq_num <= req_now.seq_num;
               req_is_picture <= req_now.is_picture;
               req_request_length <= req_now.length;
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left = $urandom_range(1, 12);
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                           : $urandom_range(1, 30);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // reply check against the oldest awaited reply
   always @(posedge clock) begin : reply_check
      queue_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         replies_seen <= replies_seen + 1;
         if (awaited_replies.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected reply: st %0d conn %h seq %h pic %b len %0d pages %0d pics %0d",
                        rsp_status, rsp_out_conn_id, rsp_out_seq_num, rsp_out_is_picture,
                        rsp_out_length, rsp_page_count, rsp_picture_count);
            mismatch_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status || rsp_out_conn_id !== want.desc.conn_id ||
                rsp_out_seq_num !== want.desc.seq_num ||
                rsp_out_is_picture !== want.desc.is_picture ||
                rsp_out_length !== want.desc.length || rsp_page_count !== want.page_count ||
                rsp_picture_count !== want.picture_count) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("reply mismatch: expected st %0d conn %h seq %h pic %b len %0d",
                           want.status, want.desc.conn_id, want.desc.seq_num,
                           want.desc.is_picture, want.desc.length);
                  $display("   expected pages %0d pics %0d", want.page_count,
                           want.picture_count);
                  $display("   actual st %0d conn %h seq %h pic %b len %0d pages %0d pics %0d",
                           rsp_status, rsp_out_conn_id, rsp_out_seq_num, rsp_out_is_picture,
                           rsp_out_length, rsp_page_count, rsp_picture_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int phase_no;
      int random_sent;
      int n;
      int push_pct;
      int pic_pct;
      sched_mode_type mode_pick;
      logic [CSR_DATA_W-1:0] cap_pick;
      logic [2:0] junk;
      logic [31:0] rnd;
      logic kind;
      logic pic;
      logic [CONN_W-1:0] conn;
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] len;

      phase_no = 0;
      random_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty pop, field extremes, a picture kept in the page ring
      add_request(KIND_POP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, LEN_MAX, 1'b0);
      add_request(KIND_PUSH, 16'h0000, 32'h0000_0000, 1'b0, 13'd0, 1'b0);
      add_request(KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, LEN_MAX, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      drain_queue();

      // capacity zero behaves as one, pictures first, full push rejected
      csr_write(CSR_MODE, {3'b111, MODE_HPIC});
      csr_write(CSR_CAPACITY, 5'd0);
      add_request(KIND_PUSH, 16'h0001, 32'h0000_0011, 1'b1, 13'd100, 1'b0);
      add_request(KIND_PUSH, 16'h0002, 32'h0000_0012, 1'b0, 13'd200, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_PUSH, 16'h0003, 32'h0000_0013, 1'b0, 13'd300, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      drain_queue();

      // shared limit of two across both classes
      csr_write(CSR_CAPACITY, 5'd2);
      add_request(KIND_PUSH, 16'h0004, 32'h0000_0014, 1'b0, 13'd1, 1'b0);
      add_request(KIND_PUSH, 16'h0005, 32'h0000_0015, 1'b1, 13'd2, 1'b0);
      add_request(KIND_PUSH, 16'h0006, 32'h0000_0016, 1'b1, 13'd3, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      drain_queue();

      // pages first, capacity above depth clips to depth
      csr_write(CSR_MODE, {3'b000, MODE_HPHC});
      csr_write(CSR_CAPACITY, 5'd31);
      add_request(KIND_PUSH, 16'h0007, 32'h0000_0017, 1'b1, 13'd4, 1'b0);
      add_request(KIND_PUSH, 16'h0008, 32'h0000_0018, 1'b0, 13'd5, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      drain_queue();

      // picture left behind after a switch to fifo, served again in a priority mode
      csr_write(CSR_MODE, {3'b010, MODE_HPIC});
      add_request(KIND_PUSH, 16'h0009, 32'h0000_0019, 1'b1, 13'd6, 1'b0);
      drain_queue();
      csr_write(CSR_MODE, {3'b101, MODE_FIFO});
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      add_request(KIND_PUSH, 16'h000A, 32'h0000_001A, 1'b0, 13'd7, 1'b0);
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);
      drain_queue();
      csr_write(CSR_MODE, {3'b000, MODE_HPHC});
      add_request(KIND_POP, 16'h0000, 32'h0, 1'b0, 13'd0, 1'b0);

      // random phases, each with its own mode, capacity and push/pop mix
      while (random_sent < RANDOM_WORDS) begin
         drain_queue();
         if (phase_no == 0) begin
            // full-size rings first so every slot of both rings can get written
            mode_pick = MODE_HPIC;
            cap_pick = 5'd16;
         end else begin
            mode_pick = sched_mode_type'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
               0: cap_pick = 5'd0;
               1: cap_pick = 5'd1;
               2: cap_pick = 5'd16;
               3: cap_pick = 5'd31;
               4: begin
                  rnd = $urandom_range(17, 30);
                  cap_pick = rnd[CAP_W-1:0];
               end
               default: begin
                  rnd = $urandom_range(2, 15);
                  cap_pick = rnd[CAP_W-1:0];
               end
            endcase
         end
         rnd = $urandom;
         junk = rnd[2:0];
         csr_write(CSR_MODE, {junk, mode_pick});
         // resizing an occupied ring is safe only once no slot is left unwritten
         if (page_fill + pic_fill == 0 || (&page_written && &pic_written))
            csr_write(CSR_CAPACITY, cap_pick);
         case ($urandom_range(0, 3))
            0: push_pct = 25;
            1: push_pct = 50;
            2: push_pct = 65;
            default: push_pct = 85;
         endcase
         pic_pct = $urandom_range(15, 85);
         n = $urandom_range(60, 160);
         if (n > RANDOM_WORDS - random_sent) n = RANDOM_WORDS - random_sent;
         for (int i = 0; i < n; i++) begin
            kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            pic = $urandom_range(0, 99) < pic_pct;
            rnd = $urandom;
            conn = rnd[CONN_W-1:0];
            if ($urandom_range(0, 15) == 0) conn = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            seq = $urandom;
            if ($urandom_range(0, 15) == 0) seq = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            rnd = $urandom_range(0, 8096);
            len = rnd[LEN_W-1:0];
            if ($urandom_range(0, 15) == 0) len = $urandom_range(0, 1) ? LEN_MAX : 13'd0;
            add_request(kind, conn, seq, pic, len, $urandom_range(0, 99) == 0);
         end
         random_sent += n;
         phase_no++;
      end

      drain_queue();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/dcpq_pkg.sv
rtl/dcpq_ram.sv
rtl/dcpq_ctrl.sv
rtl/dcpq_datapath.sv
rtl/dual_class_priority_request_queue_top.sv
dv/tb_dual_class_priority_request_queue_top.sv
